// ===== hw/rtl/mvp_pkg.sv =====
// ----------------------------------------------------------------------------
// mvp_pkg: shared definitions for the motion vector predictor
// Slot map, operating modes, scan order table, sequencer states and the
// structs passed between the neighbor locator, the store and the select unit.
// ----------------------------------------------------------------------------
package mvp_pkg;

  localparam int MV_WIDTH_DEF = 14;
  localparam int REF_W        = 6;
  localparam int SLOT_W       = 5;
  localparam int NUM_SLOTS    = 26;
  localparam int NUM_LISTS    = 2;
  localparam int STORE_DEPTH  = NUM_LISTS * NUM_SLOTS;
  localparam int STORE_AW     = $clog2(STORE_DEPTH);
  localparam int NUM_NBR      = 4;

  // Operating modes of an input transaction.
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_PRED  = 2'd1;
  localparam logic [1:0] MODE_SKIP  = 2'd2;

  // Store slots outside the current macroblock.
  localparam logic [SLOT_W-1:0] SLOT_LEFT     = 5'd16;
  localparam logic [SLOT_W-1:0] SLOT_TOP      = 5'd20;
  localparam logic [SLOT_W-1:0] SLOT_TOPRIGHT = 5'd24;
  localparam logic [SLOT_W-1:0] SLOT_TOPLEFT  = 5'd25;

  // Neighbor positions in the capture registers.
  localparam int NBR_A = 0;
  localparam int NBR_B = 1;
  localparam int NBR_C = 2;
  localparam int NBR_D = 3;

  // Z-scan rank of each 4x4 block, indexed by raster position.
  localparam logic [3:0] Z_ORDER [16] = '{
    4'd0, 4'd1, 4'd4, 4'd5, 4'd2, 4'd3, 4'd6, 4'd7,
    4'd8, 4'd9, 4'd12, 4'd13, 4'd10, 4'd11, 4'd14, 4'd15
  };

  // Where a neighbor lives and, inside the current macroblock, whether it exists.
  typedef struct packed {
    logic              in_store;
    logic              exists_cur;
    logic [SLOT_W-1:0] slot;
  } nbr_loc_t;

  // Control for the select unit.
  typedef struct packed {
    logic       skip;
    logic       x4_zero;
    logic       y4_zero;
    logic       wide_half;
    logic       tall_half;
    logic [4:0] tref;
    logic       comp_y;
  } sel_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_AB,
    ST_RD_CD,
    ST_CAP,
    ST_CALC_X,
    ST_CALC_Y,
    ST_DONE
  } mvp_state_t;

  typedef enum logic [2:0] {
    PICK_A,
    PICK_B,
    PICK_C,
    PICK_MEDIAN,
    PICK_ZERO
  } pick_t;

endpackage

// ===== hw/rtl/mvp_store.sv =====
// ----------------------------------------------------------------------------
// mvp_store: neighbor entry store
// One write port and two registered read ports over both reference lists.
// Per-entry valid bits make entries never written read as the reset value.
// ----------------------------------------------------------------------------
module mvp_store
  import mvp_pkg::*;
#(
  parameter int MV_WIDTH = MV_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [STORE_AW-1:0]        wr_addr,
  input  logic                       wr_avail,
  input  logic signed [REF_W-1:0]    wr_ref,
  input  logic signed [MV_WIDTH-1:0] wr_mvx,
  input  logic signed [MV_WIDTH-1:0] wr_mvy,
  input  logic [STORE_AW-1:0]        rd_addr  [2],
  output logic                       rd_avail [2],
  output logic signed [REF_W-1:0]    rd_ref   [2],
  output logic signed [MV_WIDTH-1:0] rd_mvx   [2],
  output logic signed [MV_WIDTH-1:0] rd_mvy   [2]
);

  localparam int ENTRY_W = 1 + REF_W + 2 * MV_WIDTH;

  logic [ENTRY_W-1:0]     mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] vld;
  logic [ENTRY_W-1:0]     rd_data [2];
  logic                   rd_vld  [2];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_avail, wr_ref, wr_mvx, wr_mvy};
    end
    for (int p = 0; p < 2; p++) begin
      rd_data[p] <= mem[rd_addr[p]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      for (int p = 0; p < 2; p++) begin
        rd_vld[p] <= 1'b0;
      end
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      for (int p = 0; p < 2; p++) begin
        rd_vld[p] <= vld[rd_addr[p]];
      end
    end
  end

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      if (rd_vld[p]) begin
        {rd_avail[p], rd_ref[p], rd_mvx[p], rd_mvy[p]} = rd_data[p];
      end else begin
        rd_avail[p] = 1'b0;
        rd_ref[p]   = '0;
        rd_mvx[p]   = '0;
        rd_mvy[p]   = '0;
      end
    end
  end

endmodule

// ===== hw/rtl/mvp_locate.sv =====
// ----------------------------------------------------------------------------
// mvp_locate: neighbor locator
// Maps a partition's top-left block and width to the slots of neighbors
// A, B, C and D, and decides existence inside the current macroblock.
// ----------------------------------------------------------------------------
module mvp_locate
  import mvp_pkg::*;
(
  input  logic [3:0] blk,
  input  logic [2:0] width,
  output nbr_loc_t   loc [NUM_NBR]
);

  logic [1:0] x4;
  logic [1:0] y4;
  logic [1:0] xm1;
  logic [1:0] ym1;
  logic [3:0] xc;

  function automatic nbr_loc_t store_loc(logic [SLOT_W-1:0] s);
    nbr_loc_t l;
    l.in_store   = 1'b1;
    l.exists_cur = 1'b0;
    l.slot       = s;
    return l;
  endfunction

  // A block of the current macroblock exists only if it comes earlier in Z-scan.
  function automatic nbr_loc_t cur_loc(logic [3:0] s, logic [3:0] cur);
    nbr_loc_t l;
    l.in_store   = 1'b0;
    l.exists_cur = (Z_ORDER[s] < Z_ORDER[cur]);
    l.slot       = {1'b0, s};
    return l;
  endfunction

  always_comb begin
    x4  = blk[1:0];
    y4  = blk[3:2];
    xm1 = x4 - 2'd1;
    ym1 = y4 - 2'd1;
    xc  = {2'b00, x4} + {1'b0, width};

    if (x4 == 2'd0) begin
      loc[NBR_A] = store_loc(SLOT_LEFT + {3'b000, y4});
    end else begin
      loc[NBR_A] = cur_loc({y4, xm1}, blk);
    end

    if (y4 == 2'd0) begin
      loc[NBR_B] = store_loc(SLOT_TOP + {3'b000, x4});
    end else begin
      loc[NBR_B] = cur_loc({ym1, x4}, blk);
    end

    if (y4 == 2'd0) begin
      if (xc > 4'd3) begin
        loc[NBR_C] = store_loc(SLOT_TOPRIGHT);
      end else begin
        loc[NBR_C] = store_loc(SLOT_TOP + {3'b000, xc[1:0]});
      end
    end else if (xc > 4'd3) begin
      loc[NBR_C] = '0;
    end else begin
      loc[NBR_C] = cur_loc({ym1, xc[1:0]}, blk);
    end

    if (x4 == 2'd0 && y4 == 2'd0) begin
      loc[NBR_D] = store_loc(SLOT_TOPLEFT);
    end else if (x4 == 2'd0) begin
      loc[NBR_D] = store_loc(SLOT_LEFT + {3'b000, ym1});
    end else if (y4 == 2'd0) begin
      loc[NBR_D] = store_loc(SLOT_TOP + {3'b000, xm1});
    end else begin
      loc[NBR_D] = cur_loc({ym1, xm1}, blk);
    end
  end

endmodule

// ===== hw/rtl/mvp_select.sv =====
// ----------------------------------------------------------------------------
// mvp_select: shared select and median unit
// Chooses among the neighbor rules and produces one vector component per
// use; the sequencer runs it once for x and once for y.
// ----------------------------------------------------------------------------
module mvp_select
  import mvp_pkg::*;
#(
  parameter int MV_WIDTH = MV_WIDTH_DEF
) (
  input  sel_ctl_t                   ctl,
  input  logic                       nb_ex  [NUM_NBR],
  input  logic signed [REF_W-1:0]    nb_ref [NUM_NBR],
  input  logic signed [MV_WIDTH-1:0] nb_mvx [NUM_NBR],
  input  logic signed [MV_WIDTH-1:0] nb_mvy [NUM_NBR],
  output logic signed [MV_WIDTH-1:0] res
);

  logic                       ea, eb, ec, use_c;
  logic signed [REF_W-1:0]    ra, rb, rc, tref6;
  logic signed [MV_WIDTH-1:0] ma, mb, mc;
  logic signed [MV_WIDTH-1:0] lo_ab, hi_ab, mid_t, med;
  logic                       hit_a, hit_b, hit_c, one_hit;
  logic                       zero_a, zero_b;
  pick_t                      pick;

  always_comb begin
    ea    = nb_ex[NBR_A];
    eb    = nb_ex[NBR_B];
    use_c = nb_ex[NBR_C];
    ec    = nb_ex[NBR_C] | nb_ex[NBR_D];
    ra    = nb_ref[NBR_A];
    rb    = nb_ref[NBR_B];
    rc    = use_c ? nb_ref[NBR_C] : nb_ref[NBR_D];
    if (ctl.comp_y) begin
      ma = nb_mvy[NBR_A];
      mb = nb_mvy[NBR_B];
      mc = use_c ? nb_mvy[NBR_C] : nb_mvy[NBR_D];
    end else begin
      ma = nb_mvx[NBR_A];
      mb = nb_mvx[NBR_B];
      mc = use_c ? nb_mvx[NBR_C] : nb_mvx[NBR_D];
    end

    // Only A available: it stands in for B and C as well.
    if (!eb && !ec && ea) begin
      rb = ra;
      rc = ra;
      mb = ma;
      mc = ma;
    end

    tref6   = {1'b0, ctl.tref};
    hit_a   = (ra == tref6);
    hit_b   = (rb == tref6);
    hit_c   = (rc == tref6);
    one_hit = (hit_a & ~hit_b & ~hit_c) | (~hit_a & hit_b & ~hit_c)
            | (~hit_a & ~hit_b & hit_c);

    zero_a = (nb_ref[NBR_A] == '0) && (nb_mvx[NBR_A] == '0) && (nb_mvy[NBR_A] == '0);
    zero_b = (nb_ref[NBR_B] == '0) && (nb_mvx[NBR_B] == '0) && (nb_mvy[NBR_B] == '0);

    if (ctl.skip && (!ea || !eb || zero_a || zero_b)) begin
      pick = PICK_ZERO;
    end else if (ctl.wide_half && ctl.y4_zero && hit_b) begin
      pick = PICK_B;
    end else if (ctl.wide_half && !ctl.y4_zero && hit_a) begin
      pick = PICK_A;
    end else if (ctl.tall_half && ctl.x4_zero && hit_a) begin
      pick = PICK_A;
    end else if (ctl.tall_half && !ctl.x4_zero && hit_c) begin
      pick = PICK_C;
    end else if (one_hit) begin
      pick = hit_a ? PICK_A : (hit_b ? PICK_B : PICK_C);
    end else begin
      pick = PICK_MEDIAN;
    end

    // median = max(min(a, b), min(max(a, b), c))
    lo_ab = (ma < mb) ? ma : mb;
    hi_ab = (ma < mb) ? mb : ma;
    mid_t = (hi_ab < mc) ? hi_ab : mc;
    med   = (lo_ab > mid_t) ? lo_ab : mid_t;

    case (pick)
      PICK_A:      res = ma;
      PICK_B:      res = mb;
      PICK_C:      res = mc;
      PICK_MEDIAN: res = med;
      PICK_ZERO:   res = '0;
      default:     res = '0;
    endcase
  end

endmodule

// ===== hw/rtl/motion_vector_predictor.sv =====
// ----------------------------------------------------------------------------
// motion_vector_predictor: H.264 motion vector predictor with neighbor store
//
//   Channel | Direction | Handshake              | Payload
//   in      | input     | in_valid / in_ready    | mode, ref_list, slot, entry_*,
//           |           |                        | partition_block, part_*, target_ref
//   out     | output    | out_valid / out_ready  | pred_mvx, pred_mvy
//
// A write transaction is accepted in ST_IDLE and leaves in_ready high.
// A predict or skip transaction, after the accepting edge, runs through the states:
// store reads over the dual-port store (ST_RD_AB for A/B, then ST_RD_CD for
// C/D), a capture state (ST_CAP), and two passes of the shared select unit
// (ST_CALC_X for x, then ST_CALC_Y for y). Its result is offered once the
// output register is free, from ST_CALC_Y or ST_DONE, and in_ready returns with it.
// A result waits in the output register; the next transaction is accepted
// meanwhile, and a new result waits in the sequencer until the register frees.
// Synchronous reset clears the sequencer, the output valid and the store's
// valid bits, so every store entry reads as unavailable right after reset.
// ----------------------------------------------------------------------------
module motion_vector_predictor
  import mvp_pkg::*;
#(
  parameter int MV_WIDTH = MV_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 mode,
  input  logic                       ref_list,
  input  logic [SLOT_W-1:0]          slot,
  input  logic                       entry_avail,
  input  logic signed [REF_W-1:0]    entry_ref,
  input  logic signed [MV_WIDTH-1:0] entry_mvx,
  input  logic signed [MV_WIDTH-1:0] entry_mvy,
  input  logic [3:0]                 partition_block,
  input  logic [2:0]                 part_width,
  input  logic [2:0]                 part_height,
  input  logic [4:0]                 target_ref,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [MV_WIDTH-1:0] pred_mvx,
  output logic signed [MV_WIDTH-1:0] pred_mvy
);

  mvp_state_t state, state_next;

  logic       item_list;
  logic [3:0] item_blk;
  logic [2:0] item_w;
  logic [2:0] item_h;
  logic [4:0] item_tref;
  logic       item_skip;

  logic                       nb_ex  [NUM_NBR];
  logic signed [REF_W-1:0]    nb_ref [NUM_NBR];
  logic signed [MV_WIDTH-1:0] nb_mvx [NUM_NBR];
  logic signed [MV_WIDTH-1:0] nb_mvy [NUM_NBR];
  logic signed [MV_WIDTH-1:0] res_x;
  logic signed [MV_WIDTH-1:0] res_y;

  logic                       accept, start, wr_en, out_free;
  logic [STORE_AW-1:0]        wr_addr;
  logic [STORE_AW-1:0]        rd_addr  [2];
  logic                       rd_avail [2];
  logic signed [REF_W-1:0]    rd_ref   [2];
  logic signed [MV_WIDTH-1:0] rd_mvx   [2];
  logic signed [MV_WIDTH-1:0] rd_mvy   [2];
  nbr_loc_t                   loc      [NUM_NBR];
  nbr_loc_t                   port_loc [2];
  logic                       f_ex     [2];
  logic signed [REF_W-1:0]    f_ref    [2];
  logic signed [MV_WIDTH-1:0] f_mvx    [2];
  logic signed [MV_WIDTH-1:0] f_mvy    [2];
  sel_ctl_t                   ctl;
  logic signed [MV_WIDTH-1:0] sel_res;

  function automatic logic [STORE_AW-1:0] store_addr(logic lst, logic [SLOT_W-1:0] s);
    return STORE_AW'(s) + (lst ? STORE_AW'(NUM_SLOTS) : STORE_AW'(0));
  endfunction

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid & in_ready;
  assign start    = accept & ((mode == MODE_PRED) | (mode == MODE_SKIP));
  assign wr_en    = accept & (mode == MODE_WRITE) & (slot < SLOT_W'(NUM_SLOTS));
  assign wr_addr  = store_addr(ref_list, slot);
  assign out_free = ~out_valid | out_ready;

  mvp_locate u_locate (
    .blk   (item_blk),
    .width (item_w),
    .loc   (loc)
  );

  // The first read state fetches A and B, the second C and D.
  always_comb begin
    if (state == ST_RD_AB) begin
      rd_addr[0] = store_addr(item_list, loc[NBR_A].slot);
      rd_addr[1] = store_addr(item_list, loc[NBR_B].slot);
    end else begin
      rd_addr[0] = store_addr(item_list, loc[NBR_C].slot);
      rd_addr[1] = store_addr(item_list, loc[NBR_D].slot);
    end
    if (state == ST_CAP) begin
      port_loc[0] = loc[NBR_C];
      port_loc[1] = loc[NBR_D];
    end else begin
      port_loc[0] = loc[NBR_A];
      port_loc[1] = loc[NBR_B];
    end
  end

  mvp_store #(.MV_WIDTH(MV_WIDTH)) u_store (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_avail (entry_avail),
    .wr_ref   (entry_ref),
    .wr_mvx   (entry_mvx),
    .wr_mvy   (entry_mvy),
    .rd_addr  (rd_addr),
    .rd_avail (rd_avail),
    .rd_ref   (rd_ref),
    .rd_mvx   (rd_mvx),
    .rd_mvy   (rd_mvy)
  );

  // A missing neighbor or one with a negative reference reads as ref -1, zero vector.
  always_comb begin
    for (int p = 0; p < 2; p++) begin
      f_ex[p] = port_loc[p].in_store ? rd_avail[p] : port_loc[p].exists_cur;
      if (!f_ex[p] || rd_ref[p][REF_W-1]) begin
        f_ref[p] = '1;
        f_mvx[p] = '0;
        f_mvy[p] = '0;
      end else begin
        f_ref[p] = rd_ref[p];
        f_mvx[p] = rd_mvx[p];
        f_mvy[p] = rd_mvy[p];
      end
    end
  end

  always_comb begin
    ctl.skip      = item_skip;
    ctl.x4_zero   = (item_blk[1:0] == 2'd0);
    ctl.y4_zero   = (item_blk[3:2] == 2'd0);
    ctl.wide_half = (item_w == 3'd4) && (item_h == 3'd2);
    ctl.tall_half = (item_w == 3'd2) && (item_h == 3'd4);
    ctl.tref      = item_tref;
    ctl.comp_y    = (state == ST_CALC_Y);
  end

  mvp_select #(.MV_WIDTH(MV_WIDTH)) u_select (
    .ctl    (ctl),
    .nb_ex  (nb_ex),
    .nb_ref (nb_ref),
    .nb_mvx (nb_mvx),
    .nb_mvy (nb_mvy),
    .res    (sel_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (start) state_next = ST_RD_AB;
      ST_RD_AB:  state_next = ST_RD_CD;
      ST_RD_CD:  state_next = ST_CAP;
      ST_CAP:    state_next = ST_CALC_X;
      ST_CALC_X: state_next = ST_CALC_Y;
      ST_CALC_Y: state_next = out_free ? ST_IDLE : ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Skip always predicts a 16x16 partition on list 0 with reference 0.
  always_ff @(posedge clk) begin
    if (start) begin
      item_skip <= (mode == MODE_SKIP);
      if (mode == MODE_SKIP) begin
        item_list <= 1'b0;
        item_blk  <= 4'd0;
        item_w    <= 3'd4;
        item_h    <= 3'd4;
        item_tref <= 5'd0;
      end else begin
        item_list <= ref_list;
        item_blk  <= partition_block;
        item_w    <= part_width;
        item_h    <= part_height;
        item_tref <= target_ref;
      end
    end
    if (state == ST_RD_CD) begin
      nb_ex[NBR_A]  <= f_ex[0];
      nb_ref[NBR_A] <= f_ref[0];
      nb_mvx[NBR_A] <= f_mvx[0];
      nb_mvy[NBR_A] <= f_mvy[0];
      nb_ex[NBR_B]  <= f_ex[1];
      nb_ref[NBR_B] <= f_ref[1];
      nb_mvx[NBR_B] <= f_mvx[1];
      nb_mvy[NBR_B] <= f_mvy[1];
    end
    if (state == ST_CAP) begin
      nb_ex[NBR_C]  <= f_ex[0];
      nb_ref[NBR_C] <= f_ref[0];
      nb_mvx[NBR_C] <= f_mvx[0];
      nb_mvy[NBR_C] <= f_mvy[0];
      nb_ex[NBR_D]  <= f_ex[1];
      nb_ref[NBR_D] <= f_ref[1];
      nb_mvx[NBR_D] <= f_mvx[1];
      nb_mvy[NBR_D] <= f_mvy[1];
    end
    if (state == ST_CALC_X) begin
      res_x <= sel_res;
    end
    if (state == ST_CALC_Y) begin
      res_y <= sel_res;
    end
    if (state == ST_CALC_Y && out_free) begin
      pred_mvx <= res_x;
      pred_mvy <= sel_res;
    end else if (state == ST_DONE && out_free) begin
      pred_mvx <= res_x;
      pred_mvy <= res_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_CALC_Y || state == ST_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_CALC_Y || $past(state) == ST_DONE))
    else $error("output valid rose outside the result states");

  a_pred_latency: assert property (@(posedge clk) disable iff (rst)
    start |=> (state == ST_RD_AB) ##5 (state == ST_IDLE || state == ST_DONE))
    else $error("prediction sequence did not finish on schedule");

  a_done_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> out_valid)
    else $error("result held back while the output register is empty");

  a_done_release: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_free) |=> (state == ST_IDLE && out_valid))
    else $error("held result was not handed to the output register");

endmodule
